/* hw/rtl/epfm_pkg.sv */
// ----------------------------------------------------------------------------
// Edge period frequency meter package
// Shared widths, register indexes, reset values and controller interface types.
// ----------------------------------------------------------------------------
package epfm_pkg;

  localparam int TIME_W = 32;
  localparam int HZ_W   = 16;
  localparam int FREQ_W = 27;
  localparam int IDX_W  = 3;

  // Quotient of the hertz scale by a period of at least one fits in this width.
  localparam int HZQ_W = 20;

  localparam logic [IDX_W-1:0] REG_MIN_PERIOD   = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_PERIOD   = 3'd1;
  localparam logic [IDX_W-1:0] REG_TONE_GAP     = 3'd2;
  localparam logic [IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd3;
  localparam logic [IDX_W-1:0] REG_TONE_LOW     = 3'd4;
  localparam logic [IDX_W-1:0] REG_TONE_HIGH    = 3'd5;

  localparam logic [TIME_W-1:0] MIN_PERIOD_RST   = 32'd20;
  localparam logic [TIME_W-1:0] MAX_PERIOD_RST   = 32'd1000000;
  localparam logic [TIME_W-1:0] TONE_GAP_RST     = 32'd700000;
  localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 32'd3000000;
  localparam logic [HZ_W-1:0]   TONE_LOW_RST     = 16'd100;
  localparam logic [HZ_W-1:0]   TONE_HIGH_RST    = 16'd8000;

  localparam logic [FREQ_W-1:0] CENTI_SCALE = 27'd100000000;
  localparam logic [FREQ_W-1:0] HZ_SCALE    = 27'd1000000;

  // One quotient bit per divider step.
  localparam int DIV_STEPS = FREQ_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic meas;
    logic div_last;
  } sts_t;

endpackage

/* hw/rtl/epfm_in_if.sv */
// ----------------------------------------------------------------------------
// Edge period frequency meter input channel
// Valid/ready channel carrying one timestamp sample or edge.
// ----------------------------------------------------------------------------
interface epfm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [epfm_pkg::TIME_W-1:0] now_us;

  modport source (output valid, output op, output now_us, input ready);
  modport sink   (input valid, input op, input now_us, output ready);
endinterface

/* hw/rtl/epfm_out_if.sv */
// ----------------------------------------------------------------------------
// Edge period frequency meter result channel
// Valid/ready channel carrying one measurement result.
// ----------------------------------------------------------------------------
interface epfm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        measured;
  logic [epfm_pkg::TIME_W-1:0] period_us;
  logic [epfm_pkg::FREQ_W-1:0] freq_centihz;
  logic                        beep;
  logic [epfm_pkg::HZ_W-1:0]   beep_hz;
  logic                        pulse_active;
  logic                        went_idle;

  modport source (output valid, output measured, output period_us, output freq_centihz,
                  output beep, output beep_hz, output pulse_active, output went_idle,
                  input ready);
  modport sink   (input valid, input measured, input period_us, input freq_centihz,
                  input beep, input beep_hz, input pulse_active, input went_idle,
                  output ready);
endinterface

/* hw/rtl/epfm_cfg_if.sv */
// ----------------------------------------------------------------------------
// Edge period frequency meter configuration channel
// Valid/ready register write channel with index and data.
// ----------------------------------------------------------------------------
interface epfm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [epfm_pkg::IDX_W-1:0]  index;
  logic [epfm_pkg::TIME_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/epfm_ctrl.sv */
// ----------------------------------------------------------------------------
// Edge period frequency meter controller
// Sequences capture, evaluation, serial division and result hand-off.
// ----------------------------------------------------------------------------
module epfm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output epfm_pkg::cmd_t cmd,
  input  epfm_pkg::sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.meas ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // The result register may still hold an earlier transaction.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.load_out | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/epfm_dp.sv */
// ----------------------------------------------------------------------------
// Edge period frequency meter datapath
// Configuration, timing state, window checks, two-lane serial divider, results.
// ----------------------------------------------------------------------------
module epfm_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  epfm_pkg::cmd_t              cmd,
  output epfm_pkg::sts_t              sts,
  input  logic                        cfg_we,
  input  logic [epfm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [epfm_pkg::TIME_W-1:0] cfg_data,
  input  logic                        op,
  input  logic [epfm_pkg::TIME_W-1:0] now_us,
  output logic                        measured,
  output logic [epfm_pkg::TIME_W-1:0] period_us,
  output logic [epfm_pkg::FREQ_W-1:0] freq_centihz,
  output logic                        beep,
  output logic [epfm_pkg::HZ_W-1:0]   beep_hz,
  output logic                        pulse_active,
  output logic                        went_idle
);

  // Configuration registers
  logic [epfm_pkg::TIME_W-1:0] min_period;
  logic [epfm_pkg::TIME_W-1:0] max_period;
  logic [epfm_pkg::TIME_W-1:0] tone_gap;
  logic [epfm_pkg::TIME_W-1:0] idle_timeout;
  logic [epfm_pkg::HZ_W-1:0]   tone_low;
  logic [epfm_pkg::HZ_W-1:0]   tone_high;

  // Timing state
  logic [epfm_pkg::TIME_W-1:0] last_edge_time;
  logic [epfm_pkg::TIME_W-1:0] last_pulse_time;
  logic [epfm_pkg::TIME_W-1:0] last_tone_time;
  logic                        active_flag;

  // Captured item and per-item decisions
  logic                        op_q;
  logic [epfm_pkg::TIME_W-1:0] now_q;
  logic                        r_meas;
  logic                        r_beep;
  logic                        r_went_idle;
  logic [epfm_pkg::TIME_W-1:0] r_period;

  // Divider
  logic [epfm_pkg::TIME_W-1:0] divisor;
  logic [epfm_pkg::TIME_W-1:0] rem_c;
  logic [epfm_pkg::TIME_W-1:0] rem_h;
  logic [epfm_pkg::FREQ_W-1:0] q_c;
  logic [epfm_pkg::FREQ_W-1:0] q_h;
  logic [epfm_pkg::CNT_W-1:0]  cnt;

  logic [epfm_pkg::TIME_W-1:0] period;
  logic                        meas_c;
  logic                        tone_due;
  logic                        idle_due;
  logic [epfm_pkg::TIME_W:0]   t_c;
  logic [epfm_pkg::TIME_W:0]   t_h;
  logic [epfm_pkg::TIME_W:0]   d_c;
  logic [epfm_pkg::TIME_W:0]   d_h;
  logic                        ge_c;
  logic                        ge_h;
  logic [epfm_pkg::HZQ_W-1:0]  hz_raw;
  logic [epfm_pkg::HZQ_W-1:0]  low_ext;
  logic [epfm_pkg::HZQ_W-1:0]  high_ext;
  logic [epfm_pkg::HZ_W-1:0]   hz_clamped;

  // All elapsed times are modulo 2^32, so plain wrapping subtraction is right.
  assign period   = now_q - last_edge_time;
  assign meas_c   = op_q && (period >= min_period) && (period <= max_period);
  assign tone_due = (now_q - last_tone_time) > tone_gap;
  // An item that just accepted a period restarts the idle window.
  assign idle_due = active_flag && !meas_c && ((now_q - last_pulse_time) > idle_timeout);

  assign sts.meas     = meas_c;
  assign sts.div_last = (cnt == epfm_pkg::CNT_W'(epfm_pkg::DIV_STEPS - 1));

  // Restoring division, one quotient bit per lane per step. The remainder
  // stays below the divisor, so the shifted value is below twice the divisor.
  assign t_c  = {rem_c, q_c[epfm_pkg::FREQ_W-1]};
  assign t_h  = {rem_h, q_h[epfm_pkg::FREQ_W-1]};
  assign d_c  = t_c - {1'b0, divisor};
  assign d_h  = t_h - {1'b0, divisor};
  assign ge_c = (t_c >= {1'b0, divisor});
  assign ge_h = (t_h >= {1'b0, divisor});

  assign hz_raw   = q_h[epfm_pkg::HZQ_W-1:0];
  assign low_ext  = {{(epfm_pkg::HZQ_W-epfm_pkg::HZ_W){1'b0}}, tone_low};
  assign high_ext = {{(epfm_pkg::HZQ_W-epfm_pkg::HZ_W){1'b0}}, tone_high};

  // Low limit checked first; with crossed limits, the rest get the high limit.
  always_comb begin
    if (hz_raw < low_ext) begin
      hz_clamped = tone_low;
    end else if (hz_raw > high_ext) begin
      hz_clamped = tone_high;
    end else begin
      hz_clamped = hz_raw[epfm_pkg::HZ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_period      <= epfm_pkg::MIN_PERIOD_RST;
      max_period      <= epfm_pkg::MAX_PERIOD_RST;
      tone_gap        <= epfm_pkg::TONE_GAP_RST;
      idle_timeout    <= epfm_pkg::IDLE_TIMEOUT_RST;
      tone_low        <= epfm_pkg::TONE_LOW_RST;
      tone_high       <= epfm_pkg::TONE_HIGH_RST;
      last_edge_time  <= '0;
      last_pulse_time <= '0;
      last_tone_time  <= '0;
      active_flag     <= 1'b0;
      cnt             <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          epfm_pkg::REG_MIN_PERIOD:   min_period   <= cfg_data;
          epfm_pkg::REG_MAX_PERIOD:   max_period   <= cfg_data;
          epfm_pkg::REG_TONE_GAP:     tone_gap     <= cfg_data;
          epfm_pkg::REG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
          epfm_pkg::REG_TONE_LOW:     tone_low     <= cfg_data[epfm_pkg::HZ_W-1:0];
          epfm_pkg::REG_TONE_HIGH:    tone_high    <= cfg_data[epfm_pkg::HZ_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.eval) begin
        cnt <= '0;
        if (op_q) begin
          last_edge_time <= now_q;
        end
        if (meas_c) begin
          last_pulse_time <= now_q;
          active_flag     <= 1'b1;
          if (tone_due) begin
            last_tone_time <= now_q;
          end
        end
        if (idle_due) begin
          active_flag <= 1'b0;
        end
      end
      if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op;
      now_q <= now_us;
    end
    if (cmd.eval) begin
      r_meas      <= meas_c;
      r_beep      <= meas_c && tone_due;
      r_went_idle <= idle_due;
      r_period    <= meas_c ? period : '0;
      // A zero period is divided as a period of one.
      divisor     <= (period == '0) ? epfm_pkg::TIME_W'(1) : period;
      rem_c       <= '0;
      rem_h       <= '0;
      q_c         <= epfm_pkg::CENTI_SCALE;
      q_h         <= epfm_pkg::HZ_SCALE;
    end
    if (cmd.div_step) begin
      rem_c <= ge_c ? d_c[epfm_pkg::TIME_W-1:0] : t_c[epfm_pkg::TIME_W-1:0];
      rem_h <= ge_h ? d_h[epfm_pkg::TIME_W-1:0] : t_h[epfm_pkg::TIME_W-1:0];
      q_c   <= {q_c[epfm_pkg::FREQ_W-2:0], ge_c};
      q_h   <= {q_h[epfm_pkg::FREQ_W-2:0], ge_h};
    end
    if (cmd.load_out) begin
      measured     <= r_meas;
      period_us    <= r_period;
      freq_centihz <= r_meas ? q_c : '0;
      beep         <= r_beep;
      beep_hz      <= r_beep ? hz_clamped : '0;
      pulse_active <= active_flag;
      went_idle    <= r_went_idle;
    end
  end

endmodule

/* hw/rtl/edge_period_frequency_meter.sv */
// Sequence: an edge with an accepted period passes capture, evaluate, 27 divider
// steps and load before its result shows; any other item skips the divider steps.
// The meter takes one item at a time, paced by the one-bit-per-cycle restoring
// divider; the input frees up once the result is loaded into a free result register.
// Reset: synchronous, clears the timing state and activity flag, restores the
// configuration defaults and empties the result register.
// ----------------------------------------------------------------------------
// Edge period frequency meter
// Reciprocal frequency counter with glitch window, beep request and idle flag.
// ----------------------------------------------------------------------------
module edge_period_frequency_meter (
  input  logic       clk,
  input  logic       rst,
  epfm_in_if.sink    sample,
  epfm_out_if.source result,
  epfm_cfg_if.sink   cfg
);

  epfm_pkg::cmd_t cmd;
  epfm_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  epfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  epfm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .op           (sample.op),
    .now_us       (sample.now_us),
    .measured     (result.measured),
    .period_us    (result.period_us),
    .freq_centihz (result.freq_centihz),
    .beep         (result.beep),
    .beep_hz      (result.beep_hz),
    .pulse_active (result.pulse_active),
    .went_idle    (result.went_idle)
  );

endmodule

/* hw/rtl/epfm_checker.sv */
// ----------------------------------------------------------------------------
// Edge period frequency meter checker
// Port-level properties of the meter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module epfm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        measured,
  input logic [epfm_pkg::TIME_W-1:0] period_us,
  input logic [epfm_pkg::FREQ_W-1:0] freq_centihz,
  input logic                        beep,
  input logic [epfm_pkg::HZ_W-1:0]   beep_hz,
  input logic                        pulse_active,
  input logic                        went_idle
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // The meter works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // Without an accepted period there is no period, frequency or beep.
  a_unmeasured_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !measured) |-> (period_us == '0 && freq_centihz == '0 && !beep))
    else $error("measurement fields set without an accepted period");

  // Going idle excludes a measurement and leaves activity low; no tone without beep.
  a_idle_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!went_idle || (!measured && !pulse_active)) && (beep || beep_hz == '0)))
    else $error("inconsistent idle or beep fields");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(period_us) && $stable(freq_centihz)
                                   && $stable(beep_hz) && $stable(measured)))
    else $error("stalled result changed");

endmodule

bind edge_period_frequency_meter epfm_checker u_epfm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .measured     (result.measured),
  .period_us    (result.period_us),
  .freq_centihz (result.freq_centihz),
  .beep         (result.beep),
  .beep_hz      (result.beep_hz),
  .pulse_active (result.pulse_active),
  .went_idle    (result.went_idle)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge period frequency meter testbench
// Drives timestamped samples and edges through the valid/ready input channel,
// predicts each result from a cycle-free model of the meter and checks the
// result channel field by field. Covers the glitch window, wraparound, zero
// periods, crossed tone limits, the idle timeout and random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int  CLK_HALF        = 10;
  localparam int  RESET_CYCLES    = 4;
  localparam int  SETTLE_CYCLES   = 40;
  localparam int  CYCLE_LIMIT     = 1000000;
  localparam int  HOLD_CYCLES     = 300;
  localparam int  RANDOM_PHASES   = 6;
  localparam int  ITEMS_PER_PHASE = 320;
  localparam int  MAX_PRINTED     = 50;

  localparam bit  OP_SAMPLE = 1'b0;
  localparam bit  OP_EDGE   = 1'b1;

  localparam logic [31:0] CENTIHZ_DIVIDEND = 32'd100000000;
  localparam logic [31:0] HZ_DIVIDEND      = 32'd1000000;

  typedef struct packed {
    logic        measured;
    logic [31:0] period_us;
    logic [26:0] freq_centihz;
    logic        beep;
    logic [15:0] beep_hz;
    logic        pulse_active;
    logic        went_idle;
  } meter_result_t;

  class freq_meter_scoreboard;
    logic [31:0]   min_period;
    logic [31:0]   max_period;
    logic [31:0]   tone_gap;
    logic [31:0]   idle_timeout;
    logic [15:0]   tone_low;
    logic [15:0]   tone_high;
    logic [31:0]   last_edge;
    logic [31:0]   last_pulse;
    logic [31:0]   last_tone;
    bit            active;
    meter_result_t expected_readings[$];
    int            mismatches;
    int            results_seen;

    function new();
      min_period   = epfm_pkg::MIN_PERIOD_RST;
      max_period   = epfm_pkg::MAX_PERIOD_RST;
      tone_gap     = epfm_pkg::TONE_GAP_RST;
      idle_timeout = epfm_pkg::IDLE_TIMEOUT_RST;
      tone_low     = epfm_pkg::TONE_LOW_RST;
      tone_high    = epfm_pkg::TONE_HIGH_RST;
      last_edge    = '0;
      last_pulse   = '0;
      last_tone    = '0;
      active       = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [epfm_pkg::IDX_W-1:0] index, logic [31:0] data);
      case (index)
        epfm_pkg::REG_MIN_PERIOD:   min_period   = data;
        epfm_pkg::REG_MAX_PERIOD:   max_period   = data;
        epfm_pkg::REG_TONE_GAP:     tone_gap     = data;
        epfm_pkg::REG_IDLE_TIMEOUT: idle_timeout = data;
        epfm_pkg::REG_TONE_LOW:     tone_low     = data[15:0];
        epfm_pkg::REG_TONE_HIGH:    tone_high    = data[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // Works out the reading caused by one accepted transaction.
    function void note_sample(bit op, logic [31:0] now_us);
      meter_result_t reading;
      logic [31:0]   period;
      logic [31:0]   divisor;
      logic [31:0]   hz;
      logic [31:0]   elapsed;
      reading = '0;
      if (op == OP_EDGE) begin
        period    = now_us - last_edge;
        last_edge = now_us;
        if (period >= min_period && period <= max_period) begin
          // A zero period is divided as if it were one microsecond.
          divisor              = (period == 32'd0) ? 32'd1 : period;
          reading.measured     = 1'b1;
          reading.period_us    = period;
          reading.freq_centihz = 27'(CENTIHZ_DIVIDEND / divisor);
          last_pulse           = now_us;
          active               = 1'b1;
          elapsed              = now_us - last_tone;
          if (elapsed > tone_gap) begin
            last_tone    = now_us;
            reading.beep = 1'b1;
            hz           = HZ_DIVIDEND / divisor;
            if (hz < {16'd0, tone_low}) hz = {16'd0, tone_low};
            else if (hz > {16'd0, tone_high}) hz = {16'd0, tone_high};
            reading.beep_hz = hz[15:0];
          end
        end
      end
      elapsed = now_us - last_pulse;
      if (active && elapsed > idle_timeout) begin
        active            = 1'b0;
        reading.went_idle = 1'b1;
      end
      reading.pulse_active = active;
      expected_readings.push_back(reading);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got)
        report($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got));
    endtask

    task check_result(meter_result_t got);
      meter_result_t want;
      if (expected_readings.size() == 0) begin
        report($sformatf("result %0d arrived with no transaction pending", results_seen));
      end else begin
        want = expected_readings.pop_front();
        check_field("measured",     32'(want.measured),     32'(got.measured));
        check_field("period_us",    want.period_us,         got.period_us);
        check_field("freq_centihz", 32'(want.freq_centihz), 32'(got.freq_centihz));
        check_field("beep",         32'(want.beep),         32'(got.beep));
        check_field("beep_hz",      32'(want.beep_hz),      32'(got.beep_hz));
        check_field("pulse_active", 32'(want.pulse_active), 32'(got.pulse_active));
        check_field("went_idle",    32'(want.went_idle),    32'(got.went_idle));
      end
      results_seen++;
    endtask
  endclass

  logic clk;
  logic rst;

  epfm_in_if  sample_if();
  epfm_out_if result_if();
  epfm_cfg_if cfg_if();

  edge_period_frequency_meter u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  freq_meter_scoreboard sb;
  meter_result_t        observed;
  bit                   quiet_mode;
  int                   stall_requests;
  int                   stall_served;
  int                   hold_left;
  int                   cycle_count;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    result_if.ready = 1'b0;
    stall_served    = 0;
    hold_left       = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_served != stall_requests) begin
        stall_served++;
        hold_left = HOLD_CYCLES;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= quiet_mode || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      observed.measured     = result_if.measured;
      observed.period_us    = result_if.period_us;
      observed.freq_centihz = result_if.freq_centihz;
      observed.beep         = result_if.beep;
      observed.beep_hz      = result_if.beep_hz;
      observed.pulse_active = result_if.pulse_active;
      observed.went_idle    = result_if.went_idle;
      sb.check_result(observed);
    end
  end

  task automatic send_item(input bit op, input logic [31:0] now_us);
    @(negedge clk);
    while (!quiet_mode && $urandom_range(0, 99) < 10) begin
      sample_if.valid <= 1'b0;
      @(negedge clk);
    end
    sample_if.valid  <= 1'b1;
    sample_if.op     <= op;
    sample_if.now_us <= now_us;
    do @(posedge clk); while (!sample_if.ready);
    sb.note_sample(op, now_us);
  endtask

  // Stops offering input and waits until every expected reading has come back.
  task automatic drain();
    @(negedge clk);
    sample_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [epfm_pkg::IDX_W-1:0] index,
                           input logic [31:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_config(input logic [31:0] min_us, input logic [31:0] max_us,
                             input logic [31:0] gap_us, input logic [31:0] idle_us,
                             input logic [15:0] low_hz, input logic [15:0] high_hz);
    drain();
    write_reg(epfm_pkg::REG_MIN_PERIOD,   min_us);
    write_reg(epfm_pkg::REG_MAX_PERIOD,   max_us);
    write_reg(epfm_pkg::REG_TONE_GAP,     gap_us);
    write_reg(epfm_pkg::REG_IDLE_TIMEOUT, idle_us);
    write_reg(epfm_pkg::REG_TONE_LOW,     {16'd0, low_hz});
    write_reg(epfm_pkg::REG_TONE_HIGH,    {16'd0, high_hz});
  endtask

  initial begin
    logic [31:0] lo_period;
    logic [31:0] hi_period;
    logic [31:0] idle_us;
    logic [31:0] span;
    logic [31:0] clock_us;
    bit          kind;
    int          pick;

    sb               = new();
    quiet_mode       = 1'b0;
    stall_requests   = 0;
    cycle_count      = 0;
    rst              = 1'b1;
    sample_if.valid  = 1'b0;
    sample_if.op     = OP_SAMPLE;
    sample_if.now_us = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = epfm_pkg::REG_MIN_PERIOD;
    cfg_if.data      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: glitch window limits, tone clamps, idle timeout.
    send_item(OP_SAMPLE, 32'd0);
    send_item(OP_EDGE,   32'd0);
    send_item(OP_EDGE,   32'd19);
    send_item(OP_EDGE,   32'd39);
    send_item(OP_EDGE,   32'd1000039);
    send_item(OP_EDGE,   32'd2000040);
    send_item(OP_EDGE,   32'd2000165);
    send_item(OP_EDGE,   32'd2000265);
    send_item(OP_SAMPLE, 32'd5000265);
    send_item(OP_SAMPLE, 32'd5000266);
    send_item(OP_SAMPLE, 32'd5000267);
    send_item(OP_EDGE,   32'hFFFF_FFF0);
    send_item(OP_EDGE,   32'h0000_0010);
    send_item(OP_SAMPLE, 32'hFFFF_FFFF);

    // Only a zero period passes, so it can beep at the widest clamp.
    load_config(32'd0, 32'd0, 32'd0, 32'd0, 16'd1, 16'hFFFF);
    clock_us = 32'h8000_0000;
    send_item(OP_EDGE,   clock_us);
    send_item(OP_EDGE,   clock_us);
    send_item(OP_SAMPLE, clock_us);
    send_item(OP_SAMPLE, clock_us + 32'd1);
    send_item(OP_EDGE,   clock_us + 32'd1);

    // Crossed tone limits: low clamp wins below it, high clamp above.
    load_config(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd5000, 16'd200);
    clock_us = 32'h1234_5678;
    send_item(OP_EDGE, clock_us);
    send_item(OP_EDGE, clock_us + 32'd10000);
    send_item(OP_EDGE, clock_us + 32'd10100);
    send_item(OP_EDGE, clock_us + 32'd11100);
    send_item(OP_EDGE, clock_us + 32'd11099);

    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                16'hFFFF, 16'hFFFF);
    clock_us = 32'h5555_AAAA;
    send_item(OP_EDGE,   clock_us);
    send_item(OP_EDGE,   clock_us - 32'd1);
    send_item(OP_SAMPLE, clock_us + 32'd5);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      lo_period = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 60));
      hi_period = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF
                                              : lo_period + $urandom_range(50, 5000);
      idle_us   = $urandom_range(0, 20000);
      load_config(lo_period, hi_period, $urandom_range(0, 4000), idle_us,
                  16'($urandom_range(1, 2000)), 16'($urandom_range(1, 65535)));
      quiet_mode = (phase == 1);
      clock_us   = $urandom;
      span       = hi_period - lo_period;
      if (span > 32'd3000) span = 32'd3000;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 3 && n == 10) stall_requests++;
        if (phase == 4 && n == ITEMS_PER_PHASE / 2) drain();
        pick = $urandom_range(0, 99);
        kind = OP_EDGE;
        if (pick < 60) begin
          clock_us += lo_period + $urandom_range(0, span);
        end else if (pick < 70) begin
          // Glitch shorter than the window.
          if (lo_period != 32'd0) clock_us += $urandom_range(0, lo_period - 1);
        end else if (pick < 75) begin
          clock_us += hi_period + $urandom_range(1, 1000);
        end else if (pick < 90) begin
          kind      = OP_SAMPLE;
          clock_us += $urandom_range(0, idle_us + idle_us / 2 + 10);
        end else begin
          kind     = 1'($urandom_range(0, 1));
          clock_us = $urandom;
        end
        send_item(kind, clock_us);
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
